[design/mcct_pkg.sv]
// ----------------------------------------------------------------------------
// mcct_pkg
// shared types and codes for the controller mapping table
// ----------------------------------------------------------------------------
`default_nettype none
package mcct_pkg;

  typedef enum logic [2:0] {
    OP_ADD     = 3'd0,
    OP_REMOVE  = 3'd1,
    OP_CLEAR   = 3'd2,
    OP_CONVERT = 3'd3,
    OP_LMODE   = 3'd4,
    OP_LTARGET = 3'd5,
    OP_LEARN   = 3'd6,
    OP_NONE    = 3'd7
  } op_t;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_IGNORED   = 2'd3;

  localparam logic signed [15:0] LEARN_MAX_RESET = 16'sd16384;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic        wr;
    logic        rm;
    logic        clr;
    logic [3:0]  ch;
    logic [6:0]  ctl;
    logic [31:0] idx;
    logic [15:0] lo;
    logic [15:0] hi;
    logic        tg;
  } cmd_t;

  // lookup result handed along the chain
  typedef struct packed {
    logic        hit;
    logic        free;
    logic [31:0] idx;
    logic [15:0] lo;
    logic [15:0] hi;
    logic        tg;
  } look_t;

endpackage
`default_nettype wire

[design/midi_cc_mapping_table_with_learn.sv]
// ----------------------------------------------------------------------------
// midi_cc_mapping_table_with_learn
// controller mapping table with learn mode, built as a chain of entry cells
// ----------------------------------------------------------------------------
// after start an item passes the lookup, multiply and scale steps before the result strobe
// a new item is taken only in idle; busy is high through the lookup, multiply and output states
// the chain lookup and the multiply/divide-by-127 steps make up this work
// synchronous reset empties the table and clears learn state
// the receiver cannot stall; each result is shown for one cycle
`default_nettype none
module midi_cc_mapping_table_with_learn
  import mcct_pkg::*;
#(
  parameter int TABLE_DEPTH = 16,
  parameter int INDEX_WIDTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         op,
  input  wire logic [7:0]         status_byte,
  input  wire logic [6:0]         data_one,
  input  wire logic [6:0]         data_two,
  input  wire logic [3:0]         map_channel,
  input  wire logic [6:0]         map_controller,
  input  wire logic [15:0]        param_index,
  input  wire logic signed [15:0] min_value,
  input  wire logic signed [15:0] max_value,
  input  wire logic               toggle,
  input  wire logic               enable,
  output logic                    done,
  output logic [1:0]              result_status,
  output logic [15:0]             out_param_index,
  output logic signed [15:0]      out_value,
  output logic                    learn_active
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOOK = 4'b0010,
    S_MUL  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state;

  // latched item
  op_t         op_q;
  logic [3:0]  key_ch;
  logic [6:0]  key_ctl;
  logic [6:0]  d2_q;
  logic        cc_q;
  logic [31:0] pidx_q;
  logic [15:0] lo_q, hi_q;
  logic        tg_q, en_q;

  // learn state
  logic              learn_en, lt_set, lt_tg;
  logic [INDEX_WIDTH-1:0] lt_idx;
  logic [15:0]       lt_min, lt_max;

  // chain
  cmd_t  cmd;
  look_t chain [TABLE_DEPTH+1];
  logic  [TABLE_DEPTH-1:0] free_v;
  logic  learn_ok, do_wr;

  assign busy = (state != S_IDLE);
  assign learn_ok = learn_en && lt_set && cc_q;
  assign do_wr = (op_q == OP_ADD) || (op_q == OP_LEARN && learn_ok);

  // command to cells, only in lookup cycle
  always_comb begin
    cmd = '0;
    cmd.ch  = key_ch;
    cmd.ctl = key_ctl;
    if (op_q == OP_LEARN) begin
      cmd.idx = 32'(lt_idx);
      cmd.lo  = lt_min;
      cmd.hi  = lt_max;
      cmd.tg  = lt_tg;
    end else begin
      cmd.idx = pidx_q;
      cmd.lo  = lo_q;
      cmd.hi  = hi_q;
      cmd.tg  = tg_q;
    end
    if (state == S_LOOK) begin
      cmd.wr  = do_wr;
      cmd.rm  = (op_q == OP_REMOVE);
      cmd.clr = (op_q == OP_CLEAR);
    end
  end

  assign chain[0] = '0;

  // row of entry cells
  genvar g;
  generate
    for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      mcct_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .cmd       (cmd),
        .take_free (free_v[g] && !chain[TABLE_DEPTH].hit),
        .prev      (chain[g]),
        .next      (chain[g+1]),
        .free_here (free_v[g])
      );
    end
  endgenerate

  // registered lookup and arithmetic
  logic        hit_r, tg_r;
  logic [31:0] idx_r;
  logic signed [15:0] lo_r, hi_r;
  logic [1:0]  res_r;
  logic signed [23:0] prod;
  logic [23:0] mag;
  logic [15:0] q;
  logic signed [16:0] diff;
  logic signed [16:0] sum;

  assign diff = 17'(hi_r) - 17'(lo_r);

  // magnitude divided by 127 with rounding: multiply by ceil(2^30/127), shift by 30
  assign q = 16'(((48'(mag) + 48'd63) * 48'd8454661) >> 30);
  assign sum = 17'(lo_r) + (prod[23] ? -17'(q) : 17'(q));

  // control and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      done     <= 1'b0;
      learn_en <= 1'b0;
      lt_set   <= 1'b0;
      lt_idx   <= '0;
      lt_min   <= '0;
      lt_max   <= LEARN_MAX_RESET;
      lt_tg    <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            op_q    <= op_t'(op);
            d2_q    <= data_two;
            cc_q    <= (status_byte[7:4] == 4'hB);
            pidx_q  <= 32'(param_index[INDEX_WIDTH > 16 ? 15 : INDEX_WIDTH-1:0]);
            lo_q    <= min_value;
            hi_q    <= max_value;
            tg_q    <= toggle;
            en_q    <= enable;
            if (op == OP_CONVERT || op == OP_LEARN) begin
              key_ch  <= status_byte[3:0];
              key_ctl <= data_one;
            end else begin
              key_ch  <= map_channel;
              key_ctl <= map_controller;
            end
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          hit_r <= chain[TABLE_DEPTH].hit;
          idx_r <= chain[TABLE_DEPTH].idx;
          lo_r  <= chain[TABLE_DEPTH].lo;
          hi_r  <= chain[TABLE_DEPTH].hi;
          tg_r  <= chain[TABLE_DEPTH].tg;
          res_r <= ST_OK;
          case (op_q)
            OP_ADD: begin
              if (!chain[TABLE_DEPTH].hit && !chain[TABLE_DEPTH].free) res_r <= ST_FULL;
            end
            OP_REMOVE, OP_CONVERT: begin
              if (!chain[TABLE_DEPTH].hit) res_r <= ST_NOT_FOUND;
            end
            OP_LMODE: begin
              learn_en <= en_q;
              if (!en_q) lt_set <= 1'b0;
            end
            OP_LTARGET: begin
              lt_idx <= pidx_q[INDEX_WIDTH-1:0];
              lt_min <= lo_q;
              lt_max <= hi_q;
              lt_tg  <= tg_q;
              lt_set <= 1'b1;
            end
            OP_LEARN: begin
              if (!learn_ok) begin
                res_r <= ST_IGNORED;
              end else if (!chain[TABLE_DEPTH].hit && !chain[TABLE_DEPTH].free) begin
                res_r <= ST_FULL;
              end else begin
                learn_en <= 1'b0;
                lt_set   <= 1'b0;
              end
            end
            OP_CLEAR: ;
            default: res_r <= ST_IGNORED;
          endcase
          state <= S_MUL;
        end
        S_MUL: begin
          prod <= 24'(diff) * $signed({17'd0, d2_q});
          mag  <= 24'(diff[16] ? -diff : diff) * {17'd0, d2_q};
          state <= S_OUT;
        end
        S_OUT: begin
          done          <= 1'b1;
          result_status <= res_r;
          learn_active  <= learn_en;
          out_param_index <= '0;
          out_value     <= '0;
          if (op_q == OP_CONVERT && hit_r) begin
            out_param_index <= idx_r[15:0];
            if (!cc_q) out_value <= lo_r;
            else if (tg_r) out_value <= (d2_q != 7'd0) ? hi_r : lo_r;
            else out_value <= sum[15:0];
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[design/mcct_cell.sv]
// ----------------------------------------------------------------------------
// mcct_cell
// one table entry: key compare, hit/free chaining, write, remove and clear on command
// ----------------------------------------------------------------------------
`default_nettype none
module mcct_cell
  import mcct_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cmd_t  cmd,
  input  wire logic  take_free,
  input  wire look_t prev,
  output look_t      next,
  output logic       free_here
);

  logic        valid;
  logic [3:0]  ch;
  logic [6:0]  ctl;
  logic [31:0] idx;
  logic [15:0] lo;
  logic [15:0] hi;
  logic        tg;
  logic        match;

  assign match = valid && ch == cmd.ch && ctl == cmd.ctl;
  // first free slot: empty here and no free slot upstream
  assign free_here = !valid && !prev.free;

  // pass first match downstream and flag a free slot
  always_comb begin
    next = prev;
    if (!prev.hit && match) begin
      next.hit = 1'b1;
      next.idx = idx;
      next.lo  = lo;
      next.hi  = hi;
      next.tg  = tg;
    end
    if (!valid) next.free = 1'b1;
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (rst || cmd.clr) begin
      valid <= 1'b0;
    end else if (cmd.rm && match) begin
      valid <= 1'b0;
    end else if (cmd.wr && (match || take_free)) begin
      valid <= 1'b1;
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    if (cmd.wr && (match || take_free)) begin
      ch  <= cmd.ch;
      ctl <= cmd.ctl;
      idx <= cmd.idx;
      lo  <= cmd.lo;
      hi  <= cmd.hi;
      tg  <= cmd.tg;
    end
  end

endmodule
`default_nettype wire
